@@ design/slfd_pkg.sv @@
// Shared types and constants for the sync/length frame deframer.
// Used by slfd_front, slfd_queue, slfd_back and the top level.
`default_nettype none

package slfd_pkg;

  localparam logic [7:0]  SYNC_BYTE         = 8'hA5;
  localparam logic [7:0]  SECOND_MASK       = 8'hF0;
  localparam logic [7:0]  SECOND_MARK       = 8'h50;
  localparam logic [7:0]  DEST_MASK         = 8'h0F;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'(1024 + 1024);

  // Register index as decoded from paddr[2].
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  // A received byte together with its header classification.
  typedef struct packed {
    logic [7:0] data;
    logic       is_sync;
    logic       is_mark;
  } slfd_item_t;

  typedef struct packed {
    logic [3:0]  dest_node;
    logic [7:0]  payload_byte;
    logic        has_data;
    logic        first_of_frame;
    logic        last_of_frame;
    logic [15:0] frame_payload_len;
  } slfd_result_t;

  typedef enum logic {
    ST_TAKE,
    ST_SCAN
  } slfd_state_t;

  function automatic slfd_item_t slfd_classify(input logic [7:0] b);
    slfd_item_t it;
    it.data    = b;
    it.is_sync = (b == SYNC_BYTE);
    it.is_mark = ((b & SECOND_MASK) == SECOND_MARK);
    return it;
  endfunction

endpackage

`default_nettype wire

@@ design/slfd_front.sv @@
// Input stage of the deframer: takes stream transfers and tags each byte
// with its header checks. Depends on slfd_pkg.
`default_nettype none

module slfd_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  input  wire  [7:0]          s_tdata,
  input  wire                 q_ready,
  output logic                q_push,
  output slfd_pkg::slfd_item_t q_item
);
  import slfd_pkg::*;

  logic       held;
  slfd_item_t item;

  assign s_tready = !held || q_ready;
  assign q_push   = held;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (q_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= slfd_classify(s_tdata);
    end
  end

endmodule

`default_nettype wire

@@ design/slfd_queue.sv @@
// Short queue of classified bytes between the input stage and the frame engine.
// Depends on slfd_pkg.
`default_nettype none

module slfd_queue #(
  parameter int DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  slfd_pkg::slfd_item_t push_item,
  output logic                 push_ready,
  input  wire                  pop,
  output logic                 head_valid,
  output slfd_pkg::slfd_item_t head_item
);
  import slfd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  slfd_item_t     mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ design/slfd_back.sv @@
// Frame engine: holds the header window, drops one false-sync byte per cycle,
// counts payload and drives the registered result. Depends on slfd_pkg.
`default_nettype none

module slfd_back (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    q_valid,
  input  slfd_pkg::slfd_item_t   q_item,
  output logic                   q_pop,
  input  wire  [15:0]            max_payload,
  output logic                   out_valid,
  input  wire                    out_ready,
  output slfd_pkg::slfd_result_t out_res
);
  import slfd_pkg::*;

  slfd_state_t  state, state_next;
  slfd_item_t   win [4];
  slfd_item_t   win_next [4];
  logic [2:0]   fill, fill_next;
  logic         in_payload, in_payload_next;
  logic [15:0]  rem, rem_next;
  logic [15:0]  held_len, held_len_next;
  logic [3:0]   held_dest, held_dest_next;
  logic         out_valid_next;
  slfd_result_t out_res_next;

  logic         out_free;
  logic         take;
  logic [15:0]  cand_len;
  logic         drop;
  logic         hdr_ok;
  logic         scan_done;

  assign out_free = !out_valid || out_ready;
  assign take     = (state == ST_TAKE) && q_valid && out_free;
  assign q_pop    = take;
  assign cand_len = {win[2].data, win[3].data};

  // The front byte goes when it is not a sync byte, when the second byte lacks
  // the marker nibble, or when a complete header announces too long a payload.
  always_comb begin
    drop = (fill != 3'd0) &&
           (!win[0].is_sync ||
            (fill >= 3'd2 && !win[1].is_mark) ||
            (fill == 3'd4 && cand_len > max_payload));
    hdr_ok    = (fill == 3'd4) && !drop;
    scan_done = !drop || (fill <= 3'd1);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_TAKE: begin
        if (take && !in_payload) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_next = ST_TAKE;
      end
      default: state_next = ST_TAKE;
    endcase
  end

  always_comb begin
    win_next        = win;
    fill_next       = fill;
    in_payload_next = in_payload;
    rem_next        = rem;
    held_len_next   = held_len;
    held_dest_next  = held_dest;
    out_valid_next  = out_valid && !out_ready;
    out_res_next    = out_res;
    case (state)
      ST_TAKE: begin
        if (take) begin
          if (in_payload) begin
            out_valid_next               = 1'b1;
            out_res_next.dest_node         = held_dest;
            out_res_next.payload_byte      = q_item.data;
            out_res_next.has_data          = 1'b1;
            out_res_next.first_of_frame    = (rem == held_len);
            out_res_next.last_of_frame     = (rem == 16'd1);
            out_res_next.frame_payload_len = held_len;
            rem_next = 16'(rem - 16'd1);
            if (rem == 16'd1) in_payload_next = 1'b0;
          end else begin
            win_next[fill[1:0]] = q_item;
            fill_next           = 3'(fill + 3'd1);
          end
        end
      end
      ST_SCAN: begin
        if (drop) begin
          win_next[0] = win[1];
          win_next[1] = win[2];
          win_next[2] = win[3];
          fill_next   = 3'(fill - 3'd1);
        end else if (hdr_ok) begin
          held_dest_next = 4'(win[1].data & DEST_MASK);
          held_len_next  = cand_len;
          fill_next      = 3'd0;
          if (cand_len == 16'd0) begin
            // An empty frame still reports itself with a single marker.
            out_valid_next                 = 1'b1;
            out_res_next.dest_node         = 4'(win[1].data & DEST_MASK);
            out_res_next.payload_byte      = 8'd0;
            out_res_next.has_data          = 1'b0;
            out_res_next.first_of_frame    = 1'b1;
            out_res_next.last_of_frame     = 1'b1;
            out_res_next.frame_payload_len = 16'd0;
          end else begin
            rem_next        = cand_len;
            in_payload_next = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_TAKE;
      fill       <= 3'd0;
      in_payload <= 1'b0;
      rem        <= 16'd0;
      held_len   <= 16'd0;
      held_dest  <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      fill       <= fill_next;
      in_payload <= in_payload_next;
      rem        <= rem_next;
      held_len   <= held_len_next;
      held_dest  <= held_dest_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    win     <= win_next;
    out_res <= out_res_next;
  end

  // The engine only scans with the result register empty, so a marker never
  // overwrites a result that is still waiting.
  a_scan_out_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !out_valid)
    else $error("scan entered with a pending result");

  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 3'd4)
    else $error("header window overfilled");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (rem != 16'd0 && rem <= held_len && fill == 3'd0))
    else $error("payload counter out of step with header");

  a_pop_in_payload: assert property (@(posedge clk) disable iff (rst)
    (q_pop && in_payload) |=> out_valid)
    else $error("payload byte popped without a result");

endmodule

`default_nettype wire

@@ design/sync_length_frame_deframer.sv @@
// Deframer for A5 / 5X / length-high / length-low framed byte streams. A payload
// byte passes from the queue head straight into the result register. A header
// byte is written into the header window; the frame engine then rescans that
// window, dropping the front byte on false sync and shifting the window by one
// byte per cycle until a candidate holds or at most one byte is left. A
// four-entry queue behind the input register keeps accepting bytes while the
// engine rescans or while a result waits; the engine itself takes its next byte
// only once the result register is empty or is handed off in that cycle.
// max_payload lies at byte address 0 of the register port and resets to 2048.
// Depends on slfd_pkg, slfd_front, slfd_queue and slfd_back.
`default_nettype none

module sync_length_frame_deframer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst,
  // Input stream.
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
  // Result stream.
  output logic        m_tvalid,
  input  wire         m_tready,
  // [3:0] dest_node, [11:4] payload_byte, [12] first_of_frame,
  // [28:13] frame_payload_len, [31:29] zero
  output logic [31:0] m_tdata,
  output logic        m_tuser,   // [0] has_data
  output logic        m_tlast,   // last_of_frame
  // Register port.
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import slfd_pkg::*;

  logic         max_sel;
  logic [15:0]  max_payload;
  logic         q_push;
  logic         q_ready;
  slfd_item_t   q_in;
  logic         q_valid;
  logic         q_pop;
  slfd_item_t   q_head;
  slfd_result_t res;

  assign pready  = 1'b1;
  assign max_sel = (paddr[2] == REG_MAX_PAYLOAD);
  assign prdata  = max_sel ? {16'd0, max_payload} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && max_sel) begin
      max_payload <= pwdata[15:0];
    end
  end

  slfd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  slfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  slfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_head),
    .q_pop       (q_pop),
    .max_payload (max_payload),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_res     (res)
  );

  assign m_tdata = {3'b000, res.frame_payload_len, res.first_of_frame,
                    res.payload_byte, res.dest_node};
  assign m_tuser = res.has_data;
  assign m_tlast = res.last_of_frame;

endmodule

`default_nettype wire

@@ tb/sync_length_frame_deframer_tb.sv @@
// Self-checking testbench for sync_length_frame_deframer.
// Depends on slfd_pkg and the deframer RTL. Results are predicted in the bench
// and compared against the result stream under varied handshake pressure.
`default_nettype none

module sync_length_frame_deframer_tb;
  import slfd_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] rx_byte
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  // [3:0] dest_node, [11:4] payload_byte, [12] first_of_frame,
  // [28:13] frame_payload_len, [31:29] zero
  wire  [31:0] m_tdata;
  wire         m_tuser;          // [0] has_data
  wire         m_tlast;          // last_of_frame
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;

  sync_length_frame_deframer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Deframer state as the bench sees it.
  logic [15:0] max_len_cfg = MAX_PAYLOAD_RESET;
  logic [7:0]  hunt_win [3];
  int unsigned hunt_fill = 0;
  bit          in_frame = 1'b0;
  logic [15:0] left_bytes = '0;
  logic [15:0] frame_len = '0;
  logic [3:0]  frame_dest = '0;

  slfd_result_t expected_results [$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  bytes_sent = 0;
  int unsigned  results_checked = 0;
  int unsigned  frames_checked = 0;
  int unsigned  error_count = 0;

  // Advances the deframer by one received byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] rx, output slfd_result_t r);
    logic [7:0]  w [4];
    int unsigned n;
    int unsigned i;
    bit          drop;
    bit          held;
    logic [15:0] len;
    r = '0;
    if (in_frame && left_bytes != 0) begin
      r.dest_node         = frame_dest;
      r.payload_byte      = rx;
      r.has_data          = 1'b1;
      r.first_of_frame    = (left_bytes == frame_len);
      r.last_of_frame     = (left_bytes == 16'd1);
      r.frame_payload_len = frame_len;
      left_bytes = left_bytes - 16'd1;
      if (left_bytes == 0) in_frame = 1'b0;
      return 1'b1;
    end
    in_frame = 1'b0;
    w[0] = '0; w[1] = '0; w[2] = '0; w[3] = '0;
    n = hunt_fill;
    for (i = 0; i < n; i++) w[i] = hunt_win[i];
    w[n] = rx;
    n++;
    held = 1'b0;
    // A failed candidate loses only its front byte; the rest is checked again.
    while (n > 0 && !held) begin
      drop = 1'b0;
      if (w[0] != SYNC_BYTE) begin
        drop = 1'b1;
      end else if (n >= 2 && (w[1] & SECOND_MASK) != SECOND_MARK) begin
        drop = 1'b1;
      end else if (n < 4) begin
        held = 1'b1;
      end else begin
        len = {w[2], w[3]};
        if (len > max_len_cfg) begin
          drop = 1'b1;
        end else begin
          frame_dest = 4'(w[1] & DEST_MASK);
          frame_len  = len;
          hunt_fill  = 0;
          if (len == 0) begin
            r.dest_node      = frame_dest;
            r.first_of_frame = 1'b1;
            r.last_of_frame  = 1'b1;
            return 1'b1;
          end
          left_bytes = len;
          in_frame   = 1'b1;
          return 1'b0;
        end
      end
      if (drop) begin
        for (i = 0; i < 3; i++) w[i] = w[i+1];
        n--;
      end
    end
    for (i = 0; i < n; i++) hunt_win[i] = w[i];
    hunt_fill = n;
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    slfd_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    if (deframe_byte(b, r)) expected_results.push_back(r);
  endtask

  task automatic send_header(input logic [3:0] dest, input logic [15:0] len);
    send_byte(SYNC_BYTE);
    send_byte(SECOND_MARK | {4'h0, dest});
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  // Holds the input off until every predicted result has been seen.
  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Drains and then waits out any header rescan still running in the block.
  task automatic settle_link();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    max_len_cfg = value;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_results
    slfd_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing expected: tdata 0x%0h", m_tdata);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("dest_node", 32'(want.dest_node), 32'(m_tdata[3:0]));
        compare_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[11:4]));
        compare_field("has_data", 32'(want.has_data), 32'(m_tuser));
        compare_field("first_of_frame", 32'(want.first_of_frame), 32'(m_tdata[12]));
        compare_field("last_of_frame", 32'(want.last_of_frame), 32'(m_tlast));
        compare_field("frame_payload_len", 32'(want.frame_payload_len),
                      32'(m_tdata[28:13]));
        results_checked++;
        if (want.last_of_frame) frames_checked++;
      end
    end
  end

  // Bad first and second bytes, rescans that keep a valid partial header,
  // an oversized length, a zero-length frame and sync-like payload bytes.
  task automatic test_directed_headers();
    logic [7:0] seq [25] = '{
      8'h00,
      8'hA5, 8'hA5, 8'h5F, 8'h00, 8'h02, 8'hA5, 8'h50,
      8'hA5, 8'h40,
      8'hA5, 8'h53, 8'h08, 8'h01,
      8'hA5, 8'h50, 8'h00, 8'h00,
      8'hA5, 8'h5F, 8'hA5, 8'h5E, 8'h00, 8'h01, 8'hFF
    };
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    settle_link();
  endtask

  // Length acceptance at the register extremes and at an exact boundary.
  task automatic test_length_limits();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_max_payload(16'h0000);
    send_header(4'h1, 16'd0);
    send_header(4'h2, 16'd1);
    settle_link();
    write_max_payload(16'd3);
    send_header(4'h3, 16'd3);
    repeat (3) send_byte(8'($urandom_range(255)));
    send_header(4'h4, 16'd4);
    settle_link();
    write_max_payload(16'hFFFE);
    send_header(4'hC, 16'hFFFF);
    send_header(4'hD, 16'd24);
    repeat (24) send_byte(8'($urandom_range(255)));
    settle_link();
    write_max_payload(16'hFFFF);
    send_header(4'hE, 16'd9);
    repeat (9) send_byte(8'($urandom_range(255)));
    settle_link();
  endtask

  // Mostly well-formed frames with random content, mixed with noise and
  // broken headers, under one handshake mix and one length limit.
  task automatic test_random_traffic(input int unsigned n_bytes, input int unsigned send_pct,
                                     input int unsigned stall_pct, input logic [15:0] limit);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    int unsigned cap;
    int unsigned nib;
    logic [3:0]  dest;
    settle_link();
    write_max_payload(limit);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    cap = (limit < 16) ? int'(limit) : 16;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      dest = 4'($urandom_range(15));
      if (pick < 68) begin
        len = $urandom_range(cap);
        if (limit <= 32 && $urandom_range(7) == 0) len = 32'(limit);
        send_header(dest, 16'(len));
        repeat (len) send_byte(8'($urandom_range(255)));
      end else if (pick < 78) begin
        send_header(dest, 16'(int'(limit) + 1 + $urandom_range(65534 - int'(limit))));
      end else if (pick < 86) begin
        nib = $urandom_range(14);
        if (nib >= 5) nib++;
        send_byte(SYNC_BYTE);
        send_byte({4'(nib), 4'($urandom_range(15))});
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 4))
          send_byte(($urandom_range(7) == 0) ? SYNC_BYTE : 8'($urandom_range(255)));
      end else begin
        // Truncated header; the bytes that follow either complete it or rescan it away.
        send_byte(SYNC_BYTE);
        send_byte(SECOND_MARK | {4'h0, dest});
        if ($urandom_range(1)) send_byte(8'($urandom_range(255)));
      end
      if ($urandom_range(39) == 0) pause_until_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_headers();
    test_length_limits();
    test_random_traffic(340, 0, 0, MAX_PAYLOAD_RESET);
    test_random_traffic(340, 81, 0, 16'd12);
    test_random_traffic(340, 0, 81, 16'd20);
    test_random_traffic(340, 37, 37, 16'd6);
    settle_link();
    $display("Checked %0d results in %0d frames from %0d input transfers,",
             results_checked, frames_checked, bytes_sent);
    $display("with length limits from 0 to 65535 and four mixes of idle and stall.");
    if (error_count == 0) begin
      $display("[sync_length_frame_deframer] OK");
    end else begin
      $display("[sync_length_frame_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[sync_length_frame_deframer] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ sync_length_frame_deframer.f @@
design/slfd_pkg.sv
design/slfd_front.sv
design/slfd_queue.sv
design/slfd_back.sv
design/sync_length_frame_deframer.sv
tb/sync_length_frame_deframer_tb.sv
